/* design/rrsp_pkg.sv */
// Package for the rounded rectangle pixel shader: constants, kind codes,
// pipeline stage types and the square root step function.
// No dependencies.
package rrsp_pkg;

   localparam logic [12:0] MAX_DIM = 13'd4096;

   // Q0.16 gains, rounded up.
   localparam logic [15:0] K085 = 16'd55706;
   localparam logic [15:0] K010 = 16'd6554;
   localparam logic [15:0] K095 = 16'd62260;
   localparam logic [15:0] K090 = 16'd58983;
   localparam logic [15:0] K005 = 16'd3277;

   localparam logic [5:0] ADD_BLUE  = 6'd40;
   localparam logic [5:0] ADD_EDGE  = 6'd32;
   localparam logic [5:0] ADD_BASE  = 6'd12;
   localparam logic [5:0] ADD_SPAN  = 6'd20;

   // Reciprocal of three for values below 2^16.
   localparam logic [15:0] RECIP3 = 16'd43691;

   localparam int SQ_STEPS = 29;
   localparam int RM_STEPS = 19;
   localparam int DV_STEPS = 17;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_RADIUS = 2'd2,
      CSR_MODE   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_INTERIOR,
      KIND_ROW,
      KIND_COL,
      KIND_RIM,
      KIND_KEEP
   } kind_type;

   typedef struct packed {
      logic [30:0] rem;
      logic [28:0] root;
   } sqs_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      kind_type    kind;
      logic        lit;
      logic [10:0] radius;
      logic [12:0] width;
      logic [23:0] prod;
      logic [21:0] dsq;
      sqs_type     col;
      sqs_type     rim;
   } sq_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      kind_type    kind;
      logic        lit;
      logic [10:0] radius;
      logic [12:0] width;
      logic [18:0] rim_root;
      logic [12:0] rem;
      logic [16:0] num;
      logic [16:0] quo;
   } dv_type;

   // One digit of the square root recurrence: two radicand bits in, one root bit out.
   function automatic sqs_type sq_step(input sqs_type cur, input logic [1:0] pair);
      logic [32:0] acc;
      logic [32:0] trial;
      sqs_type     nxt;
      acc   = {cur.rem, pair};
      trial = {2'b00, cur.root, 2'b01};
      if (acc >= trial) begin
         nxt.rem  = 31'(acc - trial);
         nxt.root = {cur.root[27:0], 1'b1};
      end else begin
         nxt.rem  = acc[30:0];
         nxt.root = {cur.root[27:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

/* design/rrsp_req_if.sv */
// Input channel of the pixel shader: one source pixel per item.
// Depends on nothing.
interface rrsp_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] pixel_x;
   logic [11:0] pixel_y;
   logic [7:0]  in_blue;
   logic [7:0]  in_green;
   logic [7:0]  in_red;

   modport source (output valid, pixel_x, pixel_y, in_blue, in_green, in_red, input ready);
   modport sink (input valid, pixel_x, pixel_y, in_blue, in_green, in_red, output ready);
endinterface

/* design/rrsp_rsp_if.sv */
// Result channel of the pixel shader: one shaded pixel per item.
// Depends on nothing.
interface rrsp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_blue;
   logic [7:0] out_green;
   logic [7:0] out_red;

   modport source (output valid, out_blue, out_green, out_red, input ready);
   modport sink (input valid, out_blue, out_green, out_red, output ready);
endinterface

/* design/rounded_rect_shade_pixel.sv */
// Rounded rectangle shader: one pixel item in and one shaded item out per clock while the output
// is not stalled. The item passes 53 register stages (four front stages, 29 square root stages,
// a division load stage, 17 division stages and two gain stages). The depth is set by the
// one-bit-per-stage square root of x*(w-x)*2^34 and the restoring division by the width that
// follow it. A stall at the output holds every stage at once. The user must write configuration
// through the csr_ port only while idle; the block itself does not enforce this.
module rounded_rect_shade_pixel
   import rrsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [12:0]  csr_wdata,
   rrsp_req_if.sink     req_if,
   rrsp_rsp_if.source   rsp_if
);

   logic [12:0] cfg_width_ff;
   logic [12:0] cfg_height_ff;
   logic [10:0] cfg_radius_ff;
   logic        cfg_lit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= 13'd64;
         cfg_height_ff <= 13'd64;
         cfg_radius_ff <= 11'd0;
         cfg_lit_ff    <= 1'b0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_WIDTH:  cfg_width_ff  <= csr_wdata;
            CSR_HEIGHT: cfg_height_ff <= csr_wdata;
            CSR_RADIUS: cfg_radius_ff <= csr_wdata[10:0];
            CSR_MODE:   cfg_lit_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic ce;
   logic out_valid_ff;

   assign ce           = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = ce;

   // Stage 1: clamp sizes and radius, start the column product.
   logic [12:0] w_c, h_c, w3_c, h3_c;
   logic [10:0] r_c;
   always_comb begin
      w_c  = (cfg_width_ff > MAX_DIM) ? MAX_DIM : cfg_width_ff;
      h_c  = (cfg_height_ff > MAX_DIM) ? MAX_DIM : cfg_height_ff;
      w3_c = 13'((29'(w_c) * 29'(RECIP3)) >> 17);
      h3_c = 13'((29'(h_c) * 29'(RECIP3)) >> 17);
      r_c  = cfg_radius_ff;
      if (13'(r_c) > w3_c) r_c = w3_c[10:0];
      if (13'(r_c) > h3_c) r_c = h3_c[10:0];
   end

   logic        s1_valid_ff, s1_lit_ff, s1_out_ff;
   logic [7:0]  s1_b_ff, s1_g_ff, s1_r_ff;
   logic [11:0] s1_x_ff, s1_y_ff;
   logic [12:0] s1_w_ff, s1_h_ff;
   logic [10:0] s1_rad_ff;
   logic [23:0] s1_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (ce) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s1_b_ff    <= req_if.in_blue;
         s1_g_ff    <= req_if.in_green;
         s1_r_ff    <= req_if.in_red;
         s1_x_ff    <= req_if.pixel_x;
         s1_y_ff    <= req_if.pixel_y;
         s1_w_ff    <= w_c;
         s1_h_ff    <= h_c;
         s1_rad_ff  <= r_c;
         s1_lit_ff  <= cfg_lit_ff;
         s1_out_ff  <= (13'(req_if.pixel_x) >= w_c) || (13'(req_if.pixel_y) >= h_c);
         s1_prod_ff <= 24'(25'(req_if.pixel_x) * 25'(13'(w_c - 13'(req_if.pixel_x))));
      end
   end

   // Stage 2: corner boxes, distances from the circle centre, border tests.
   logic        s2_valid_ff, s2_lit_ff, s2_corner_ff;
   logic [7:0]  s2_b_ff, s2_g_ff, s2_r_ff;
   logic [12:0] s2_w_ff;
   logic [10:0] s2_rad_ff, s2_dx_ff, s2_dy_ff;
   logic [23:0] s2_prod_ff;
   kind_type    s2_kind_ff;

   logic [12:0] wr_c, hr_c;
   logic        xl_c, xh_c, yl_c, yh_c, corner_c;
   logic [10:0] dx_c, dy_c;
   kind_type    kind2_c;
   always_comb begin
      wr_c     = s1_w_ff - 13'(s1_rad_ff);
      hr_c     = s1_h_ff - 13'(s1_rad_ff);
      xl_c     = 13'(s1_x_ff) < 13'(s1_rad_ff);
      xh_c     = 13'(s1_x_ff) >= wr_c;
      yl_c     = 13'(s1_y_ff) < 13'(s1_rad_ff);
      yh_c     = 13'(s1_y_ff) >= hr_c;
      corner_c = (xl_c || xh_c) && (yl_c || yh_c);
      dx_c = xl_c ? 11'(13'(s1_rad_ff) - 13'(s1_x_ff)) : 11'(13'(s1_x_ff) - wr_c + 13'd1);
      dy_c = yl_c ? 11'(13'(s1_rad_ff) - 13'(s1_y_ff)) : 11'(13'(s1_y_ff) - hr_c + 13'd1);
      if (s1_out_ff) begin
         kind2_c = KIND_KEEP;
      end else if (corner_c) begin
         kind2_c = KIND_RIM;
      end else if (s1_y_ff == 12'd0 || 13'(s1_y_ff) == s1_h_ff - 13'd1) begin
         kind2_c = KIND_ROW;
      end else if (s1_x_ff == 12'd0 || 13'(s1_x_ff) == s1_w_ff - 13'd1) begin
         kind2_c = KIND_COL;
      end else begin
         kind2_c = KIND_INTERIOR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ce) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s2_b_ff      <= s1_b_ff;
         s2_g_ff      <= s1_g_ff;
         s2_r_ff      <= s1_r_ff;
         s2_w_ff      <= s1_w_ff;
         s2_rad_ff    <= s1_rad_ff;
         s2_lit_ff    <= s1_lit_ff;
         s2_prod_ff   <= s1_prod_ff;
         s2_dx_ff     <= dx_c;
         s2_dy_ff     <= dy_c;
         s2_corner_ff <= corner_c && !s1_out_ff;
         s2_kind_ff   <= kind2_c;
      end
   end

   // Stage 3: squares for the circle test.
   logic        s3_valid_ff, s3_lit_ff, s3_corner_ff;
   logic [7:0]  s3_b_ff, s3_g_ff, s3_r_ff;
   logic [12:0] s3_w_ff;
   logic [10:0] s3_rad_ff;
   logic [23:0] s3_prod_ff;
   logic [21:0] s3_dx2_ff, s3_dy2_ff, s3_rr_ff, s3_r1_ff;
   kind_type    s3_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (ce) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s3_b_ff      <= s2_b_ff;
         s3_g_ff      <= s2_g_ff;
         s3_r_ff      <= s2_r_ff;
         s3_w_ff      <= s2_w_ff;
         s3_rad_ff    <= s2_rad_ff;
         s3_lit_ff    <= s2_lit_ff;
         s3_prod_ff   <= s2_prod_ff;
         s3_corner_ff <= s2_corner_ff;
         s3_kind_ff   <= s2_kind_ff;
         s3_dx2_ff    <= 22'(s2_dx_ff) * 22'(s2_dx_ff);
         s3_dy2_ff    <= 22'(s2_dy_ff) * 22'(s2_dy_ff);
         s3_rr_ff     <= 22'(s2_rad_ff) * 22'(s2_rad_ff);
         s3_r1_ff     <= 22'(12'(s2_rad_ff) + 12'd1) * 22'(12'(s2_rad_ff) + 12'd1);
      end
   end

   // Stage 4: circle test decides the corner kind; both square roots start here.
   logic [21:0] d_c;
   kind_type    kind4_c;
   sq_type      sq_init_c;
   always_comb begin
      d_c     = s3_dx2_ff + s3_dy2_ff;
      kind4_c = s3_kind_ff;
      if (s3_corner_ff) begin
         if (d_c < s3_rr_ff) begin
            kind4_c = KIND_INTERIOR;
         end else if (d_c <= s3_r1_ff) begin
            kind4_c = KIND_RIM;
         end else begin
            kind4_c = KIND_KEEP;
         end
      end
      sq_init_c.valid  = s3_valid_ff;
      sq_init_c.blue   = s3_b_ff;
      sq_init_c.green  = s3_g_ff;
      sq_init_c.red    = s3_r_ff;
      sq_init_c.kind   = kind4_c;
      sq_init_c.lit    = s3_lit_ff;
      sq_init_c.radius = s3_rad_ff;
      sq_init_c.width  = s3_w_ff;
      sq_init_c.prod   = s3_prod_ff;
      sq_init_c.dsq    = d_c;
      sq_init_c.col    = '0;
      sq_init_c.rim    = '0;
   end

   sq_type sq_ff [0:SQ_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff[0].valid <= 1'b0;
      end else if (ce) begin
         sq_ff[0] <= sq_init_c;
      end
   end

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      sq_type nxt_c;
      always_comb begin
         nxt_c = sq_ff[k];
         if (k < 12) begin
            nxt_c.col = sq_step(sq_ff[k].col, sq_ff[k].prod[(k < 12 ? 23 - 2 * k : 1) -: 2]);
         end else begin
            nxt_c.col = sq_step(sq_ff[k].col, 2'b00);
         end
         // The rim root needs only nineteen digits; later stages carry it unchanged.
         if (k < 11) begin
            nxt_c.rim = sq_step(sq_ff[k].rim, sq_ff[k].dsq[(k < 11 ? 21 - 2 * k : 1) -: 2]);
         end else if (k < RM_STEPS) begin
            nxt_c.rim = sq_step(sq_ff[k].rim, 2'b00);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_ff[k + 1].valid <= 1'b0;
         end else if (ce) begin
            sq_ff[k + 1] <= nxt_c;
         end
      end
   end

   // Division of the root by the width: the quotient is known to fit in 17 bits, so the
   // upper root bits form the starting remainder.
   dv_type dv_ff [0:DV_STEPS];
   dv_type dv_init_c;
   always_comb begin
      dv_init_c.valid    = sq_ff[SQ_STEPS].valid;
      dv_init_c.blue     = sq_ff[SQ_STEPS].blue;
      dv_init_c.green    = sq_ff[SQ_STEPS].green;
      dv_init_c.red      = sq_ff[SQ_STEPS].red;
      dv_init_c.kind     = sq_ff[SQ_STEPS].kind;
      dv_init_c.lit      = sq_ff[SQ_STEPS].lit;
      dv_init_c.radius   = sq_ff[SQ_STEPS].radius;
      dv_init_c.width    = sq_ff[SQ_STEPS].width;
      dv_init_c.rim_root = sq_ff[SQ_STEPS].rim.root[18:0];
      dv_init_c.rem      = 13'(sq_ff[SQ_STEPS].col.root[28:17]);
      dv_init_c.num      = sq_ff[SQ_STEPS].col.root[16:0];
      dv_init_c.quo      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0].valid <= 1'b0;
      end else if (ce) begin
         dv_ff[0] <= dv_init_c;
      end
   end

   for (genvar j = 0; j < DV_STEPS; j++) begin : g_div
      dv_type      nxt_c;
      logic [13:0] acc_c;
      always_comb begin
         nxt_c = dv_ff[j];
         acc_c = {dv_ff[j].rem, dv_ff[j].num[16]};
         nxt_c.num = {dv_ff[j].num[15:0], 1'b0};
         if (acc_c >= 14'(dv_ff[j].width)) begin
            nxt_c.rem = 13'(acc_c - 14'(dv_ff[j].width));
            nxt_c.quo = {dv_ff[j].quo[15:0], 1'b1};
         end else begin
            nxt_c.rem = acc_c[12:0];
            nxt_c.quo = {dv_ff[j].quo[15:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j + 1].valid <= 1'b0;
         end else if (ce) begin
            dv_ff[j + 1] <= nxt_c;
         end
      end
   end

   // Gain stage 1: turn the column term and rim distance into gains or offsets.
   // A rim pixel on the outer circle reaches a gain just above one, hence 17 bits.
   logic [16:0] q_c;
   logic [15:0] gc_c;
   logic [16:0] grb_c, grx_c, gb_c, gg_c;
   logic [5:0]  oc_c, arb_c, arx_c, ab_c, ag_c;
   logic [19:0] diff_c;
   logic [8:0]  d8_c, nd8_c;
   always_comb begin
      q_c    = dv_ff[DV_STEPS].quo;
      gc_c   = K085 + 16'((30'(q_c) * 30'(K010)) >> 16);
      oc_c   = ADD_BASE + 6'((22'(q_c) * 22'(ADD_SPAN)) >> 16);
      diff_c = 20'(dv_ff[DV_STEPS].rim_root) - 20'({dv_ff[DV_STEPS].radius, 8'd0});
      d8_c   = (diff_c > 20'd256) ? 9'd256 : diff_c[8:0];
      nd8_c  = 9'(10'd256 - 10'(d8_c));
      grb_c  = 17'(K095) + 17'((21'(d8_c) * 21'(K005)) >> 8);
      grx_c  = 17'(K090) + 17'((23'(d8_c) * 23'(K010)) >> 8);
      arb_c  = 6'((15'(nd8_c) * 15'(ADD_BLUE)) >> 8);
      arx_c  = 6'((15'(nd8_c) * 15'(ADD_EDGE)) >> 8);
      gb_c = 17'(K095);
      gg_c = 17'(gc_c);
      ab_c = ADD_BLUE;
      ag_c = oc_c;
      case (dv_ff[DV_STEPS].kind)
         KIND_INTERIOR: ;
         KIND_ROW: begin
            gg_c = 17'(K090);
            ag_c = ADD_EDGE;
         end
         KIND_COL: begin
            gg_c = 17'(K085);
            ag_c = ADD_EDGE;
         end
         KIND_RIM: begin
            gb_c = grb_c;
            gg_c = grx_c;
            ab_c = arb_c;
            ag_c = arx_c;
         end
         default: ;
      endcase
   end

   logic        f1_valid_ff, f1_lit_ff, f1_keep_ff;
   logic [7:0]  f1_b_ff, f1_g_ff, f1_r_ff;
   logic [16:0] f1_gb_ff, f1_gg_ff;
   logic [5:0]  f1_ab_ff, f1_ag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (ce) begin
         f1_valid_ff <= dv_ff[DV_STEPS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         f1_b_ff    <= dv_ff[DV_STEPS].blue;
         f1_g_ff    <= dv_ff[DV_STEPS].green;
         f1_r_ff    <= dv_ff[DV_STEPS].red;
         f1_lit_ff  <= dv_ff[DV_STEPS].lit;
         f1_keep_ff <= dv_ff[DV_STEPS].kind == KIND_KEEP;
         f1_gb_ff   <= gb_c;
         f1_gg_ff   <= gg_c;
         f1_ab_ff   <= ab_c;
         f1_ag_ff   <= ag_c;
      end
   end

   // Gain stage 2: apply to the channels; this is the output register.
   function automatic logic [7:0] apply(input logic [7:0] p, input logic [16:0] g,
                                        input logic [5:0] a, input logic lit,
                                        input logic keep);
      logic [23:0] prod;
      logic [8:0]  sum;
      prod = 24'(p) * 24'(g);
      sum  = 9'(p) + 9'(a);
      if (keep) begin
         return p;
      end else if (lit) begin
         return sum[8] ? 8'd255 : sum[7:0];
      end else begin
         return prod[23:16];
      end
   endfunction

   logic [7:0] out_b_ff, out_g_ff, out_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ce) begin
         out_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         out_b_ff <= apply(f1_b_ff, f1_gb_ff, f1_ab_ff, f1_lit_ff, f1_keep_ff);
         out_g_ff <= apply(f1_g_ff, f1_gg_ff, f1_ag_ff, f1_lit_ff, f1_keep_ff);
         out_r_ff <= apply(f1_r_ff, f1_gg_ff, f1_ag_ff, f1_lit_ff, f1_keep_ff);
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.out_blue  = out_b_ff;
   assign rsp_if.out_green = out_g_ff;
   assign rsp_if.out_red   = out_r_ff;

   logic [3:0] front_valid;
   assign front_valid = {s1_valid_ff, s2_valid_ff, s3_valid_ff, f1_valid_ff};

   // A stalled output freezes the whole pipeline, so no item moves or disappears.
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |=> $stable(front_valid) && $stable(sq_ff[SQ_STEPS].valid)
                        && $stable(dv_ff[DV_STEPS].valid))
      else $error("pipeline moved during a stall");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid && $stable(out_b_ff)
                                         && $stable(out_g_ff) && $stable(out_r_ff))
      else $error("stalled result changed");

endmodule

/* bench/rrsp_shade_checker.sv */
// Checker for the rounded rectangle pixel shader: watches both channels and the
// register port, predicts each shaded pixel and compares it. Depends on rrsp_pkg
// and the two channel interfaces.
`timescale 1ns / 100ps
module rrsp_shade_checker
   import rrsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata,
   rrsp_req_if         req_if,
   rrsp_rsp_if         rsp_if,
   output int          fail_count,
   output int          pending_count,
   output int          shaded_count
);

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } shade_type;

   logic [12:0] img_w, img_h;
   logic [10:0] radius_req;
   logic        lighten;
   shade_type   shade_queue[$];

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] res, bitv;
      res  = '0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [7:0] scale(input logic [7:0] p, input logic [63:0] g);
      logic [63:0] v;
      v = (64'(p) * g) >> 16;
      return v[7:0];
   endfunction

   function automatic logic [7:0] lift(input logic [7:0] p, input logic [63:0] a);
      logic [63:0] v;
      v = 64'(p) + a;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   function automatic shade_type shade_pixel(input logic [11:0] px, input logic [11:0] py,
                                             input logic [7:0] b, input logic [7:0] g,
                                             input logic [7:0] rd);
      logic [63:0] w, h, x, y, r, s16, dx, dy, d, dist8, gc, oc;
      kind_type    kind;
      shade_type   o;
      w = (img_w > MAX_DIM) ? 64'(MAX_DIM) : 64'(img_w);
      h = (img_h > MAX_DIM) ? 64'(MAX_DIM) : 64'(img_h);
      x = 64'(px);
      y = 64'(py);
      o = '{b, g, rd};
      dist8 = '0;
      if (x >= w || y >= h) return o;
      r = 64'(radius_req);
      if (r > w / 3) r = w / 3;
      if (r > h / 3) r = h / 3;
      s16 = int_sqrt((x * (w - x)) << 34) / w;
      if ((x < r || x >= w - r) && (y < r || y >= h - r)) begin
         dx = (x < r) ? r - x : x - (w - r - 1);
         dy = (y < r) ? r - y : y - (h - r - 1);
         d  = dx * dx + dy * dy;
         if (d < r * r) kind = KIND_INTERIOR;
         else if (d <= (r + 1) * (r + 1)) begin
            kind  = KIND_RIM;
            dist8 = int_sqrt(d << 16) - 256 * r;
            if (dist8 > 256) dist8 = 256;
         end else kind = KIND_KEEP;
      end else if (y == 0 || y == h - 1) kind = KIND_ROW;
      else if (x == 0 || x == w - 1) kind = KIND_COL;
      else kind = KIND_INTERIOR;

      if (!lighten) begin
         gc = K085 + ((K010 * s16) >> 16);
         case (kind)
            KIND_INTERIOR: o = '{scale(b, 64'(K095)), scale(g, gc), scale(rd, gc)};
            KIND_ROW:      o = '{scale(b, 64'(K095)), scale(g, 64'(K090)),
                                 scale(rd, 64'(K090))};
            KIND_COL:      o = '{scale(b, 64'(K095)), scale(g, 64'(K085)),
                                 scale(rd, 64'(K085))};
            KIND_RIM: begin
               o = '{scale(b, K095 + ((K005 * dist8) >> 8)),
                     scale(g, K090 + ((K010 * dist8) >> 8)),
                     scale(rd, K090 + ((K010 * dist8) >> 8))};
            end
            default: ;
         endcase
      end else begin
         oc = ADD_BASE + ((ADD_SPAN * s16) >> 16);
         case (kind)
            KIND_INTERIOR: o = '{lift(b, 64'(ADD_BLUE)), lift(g, oc), lift(rd, oc)};
            KIND_ROW, KIND_COL:
               o = '{lift(b, 64'(ADD_BLUE)), lift(g, 64'(ADD_EDGE)),
                     lift(rd, 64'(ADD_EDGE))};
            KIND_RIM: begin
               o = '{lift(b, (ADD_BLUE * (256 - dist8)) >> 8),
                     lift(g, (ADD_EDGE * (256 - dist8)) >> 8),
                     lift(rd, (ADD_EDGE * (256 - dist8)) >> 8)};
            end
            default: ;
         endcase
      end
      return o;
   endfunction

   always @(posedge clock) begin
      shade_type want;
      if (reset) begin
         img_w = 13'd64;
         img_h = 13'd64;
         radius_req = '0;
         lighten = 1'b0;
         fail_count = 0;
         shaded_count = 0;
         shade_queue.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_WIDTH:  img_w = csr_wdata;
               CSR_HEIGHT: img_h = csr_wdata;
               CSR_RADIUS: radius_req = csr_wdata[10:0];
               CSR_MODE:   lighten = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready)
            shade_queue.push_back(shade_pixel(req_if.pixel_x, req_if.pixel_y,
                                              req_if.in_blue, req_if.in_green,
                                              req_if.in_red));
         if (rsp_if.valid && rsp_if.ready) begin
            shaded_count++;
            if (shade_queue.size() == 0) begin
               $error("shaded item with nothing outstanding");
               fail_count++;
            end else begin
               want = shade_queue.pop_front();
               if (rsp_if.out_blue !== want.blue) begin
                  $error("out_blue expected %0d actual %0d", want.blue, rsp_if.out_blue);
                  fail_count++;
               end
               if (rsp_if.out_green !== want.green) begin
                  $error("out_green expected %0d actual %0d", want.green, rsp_if.out_green);
                  fail_count++;
               end
               if (rsp_if.out_red !== want.red) begin
                  $error("out_red expected %0d actual %0d", want.red, rsp_if.out_red);
                  fail_count++;
               end
            end
         end
      end
      pending_count = shade_queue.size();
   end

endmodule

/* bench/rounded_rect_shade_pixel_test.sv */
// Top of the pixel shader bench: clock, reset, register writes, pixel stimulus
// and the verdict. Depends on rrsp_pkg, the channel interfaces and rrsp_shade_checker.
`timescale 1ns / 100ps
module rounded_rect_shade_pixel_test;
   import rrsp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [12:0] csr_wdata = '0;
   int          fail_count, pending_count, shaded_count;
   int          cycle_count = 0;
   int          pixel_count = 0;
   int          setting_count = 0;
   logic [12:0] cur_w, cur_h;

   rrsp_req_if req_if ();
   rrsp_rsp_if rsp_if ();

   rounded_rect_shade_pixel uut (.clock, .reset, .csr_write, .csr_index, .csr_wdata,
                                 .req_if(req_if.sink), .rsp_if(rsp_if.source));

   rrsp_shade_checker checker_i (.clock, .reset, .csr_write, .csr_index, .csr_wdata,
                                 .req_if, .rsp_if, .fail_count, .pending_count,
                                 .shaded_count);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.pixel_x = '0;
      req_if.pixel_y = '0;
      req_if.in_blue = '0;
      req_if.in_green = '0;
      req_if.in_red = '0;
      rsp_if.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("rounded_rect_shade_pixel regression: fail");
         $finish;
      end
   end

   // The receiver drops ready at random before each item it takes.
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 3);
         rsp_if.ready <= 1'b0;
         repeat (gap) @(posedge clock);
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [12:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_WIDTH) cur_w = val;
      if (idx == CSR_HEIGHT) cur_h = val;
   endtask

   task automatic apply_setting(input logic [12:0] w, input logic [12:0] h,
                                input logic [10:0] rad, input logic lit);
      req_if.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      write_reg(CSR_RADIUS, 13'(rad));
      write_reg(CSR_MODE, 13'(lit));
      setting_count++;
   endtask

   task automatic send_pixel(input logic [11:0] x, input logic [11:0] y,
                             input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
      int gap;
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.pixel_x <= x;
      req_if.pixel_y <= y;
      req_if.in_blue <= b;
      req_if.in_green <= g;
      req_if.in_red <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pixel_count++;
   endtask

   // Mostly pixels near the corners and borders of the current image, where the shading
   // rules differ; the rest anywhere inside the image or anywhere in the 12-bit range.
   task automatic random_pixel();
      logic [11:0] x, y;
      int          w, h, m;
      w = (cur_w == 0) ? 1 : ((cur_w > 4096) ? 4096 : cur_w);
      h = (cur_h == 0) ? 1 : ((cur_h > 4096) ? 4096 : cur_h);
      case ($urandom_range(0, 9))
         0: begin
            x = 12'($urandom);
            y = 12'($urandom);
         end
         1, 2, 3: begin
            x = 12'($urandom_range(0, w - 1));
            y = 12'($urandom_range(0, h - 1));
         end
         default: begin
            m = (w < 40) ? w - 1 : 39;
            x = 12'($urandom_range(0, m));
            if ($urandom_range(0, 1)) x = 12'(w - 1 - x);
            m = (h < 40) ? h - 1 : 39;
            y = 12'($urandom_range(0, m));
            if ($urandom_range(0, 1)) y = 12'(h - 1 - y);
         end
      endcase
      send_pixel(x, y, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   initial begin
      int          k;
      logic [12:0] w, h;
      cur_w = 13'd64;
      cur_h = 13'd64;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset setting: radius zero, so the image corners take the row rule.
      send_pixel(0, 0, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(63, 63, 8'hFF, 8'h00, 8'h80);
      send_pixel(0, 30, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(32, 32, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(64, 5, 8'h12, 8'h34, 8'h56);
      send_pixel(12'hFFF, 12'hFFF, 8'hAA, 8'h55, 8'h01);

      apply_setting(13'd100, 13'd60, 11'd30, 1'b0);
      for (k = 0; k < 8; k++) send_pixel(12'(k), 12'(k), 8'hFF, 8'hFF, 8'hFF);
      apply_setting(13'd100, 13'd60, 11'd1365, 1'b1);
      for (k = 0; k < 6; k++) send_pixel(12'(k), 12'(k * 2), 8'hF0, 8'hE8, 8'h00);
      send_pixel(50, 30, 8'hFF, 8'hFF, 8'hFF);
      apply_setting(13'd8191, 13'd4096, 11'd2047, 1'b1);
      send_pixel(12'd4095, 12'd4095, 8'd200, 8'd250, 8'd0);
      send_pixel(12'd2048, 12'd1, 8'd0, 8'd0, 8'd255);
      apply_setting(13'd0, 13'd3, 11'd5, 1'b0);
      send_pixel(0, 0, 8'hFF, 8'hFF, 8'hFF);
      apply_setting(13'd3, 13'd3, 11'd5, 1'b0);
      send_pixel(1, 1, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(2, 0, 8'hFF, 8'hFF, 8'hFF);

      while (pixel_count < 550) begin
         case ($urandom_range(0, 5))
            0: w = 13'($urandom_range(3, 12));
            1: w = 13'($urandom_range(0, 8191));
            2: w = 13'd4096;
            default: w = 13'($urandom_range(13, 300));
         endcase
         h = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
                                         : 13'($urandom_range(3, 300));
         apply_setting(w, h, ($urandom_range(0, 4) == 0) ? 11'($urandom)
                                                         : 11'($urandom_range(0, 60)),
                       1'($urandom));
         for (k = 0; k < 25; k++) random_pixel();
      end
      req_if.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Covered %0d pixels over %0d register settings, %0d results compared.",
               pixel_count, setting_count, shaded_count);
      if (fail_count == 0 && pending_count == 0)
         $display("rounded_rect_shade_pixel regression: pass");
      else
         $display("rounded_rect_shade_pixel regression: fail");
      $finish;
   end

endmodule
